// File: src/srit_pkg.sv
// ----------------------------------------------------------------------------
// srit_pkg - segment/rectangle intersect test package
// Shared widths and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package srit_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_WIDTH-1:0]  t_diff;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;
    typedef logic signed [SUM_WIDTH-1:0]   t_sum;

    typedef enum logic [1:0] {
        CFG_CLIP_LEFT   = 2'd0,
        CFG_CLIP_TOP    = 2'd1,
        CFG_CLIP_RIGHT  = 2'd2,
        CFG_CLIP_BOTTOM = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

// File: src/segment_rect_intersect_test_unit.sv
// ----------------------------------------------------------------------------
// segment_rect_intersect_test_unit - segment versus clip rectangle hit test
// Throughput: one item per cycle; start is taken whenever busy is low.
// Four register stages: sort/clip, differences, products, sign combine.
// The receiver cannot stall; results are never held back or dropped.
// Reset (synchronous, active low) clears the clip registers to 0, empties the
// pipeline and holds busy high while asserted.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_rect_intersect_test_unit
    import srit_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // item channel
    input  wire logic        start,
    output logic             busy,
    input  wire t_coord      i_start_x,
    input  wire t_coord      i_start_y,
    input  wire t_coord      i_end_x,
    input  wire t_coord      i_end_y,
    // result strobe
    output logic             o_hit_valid,
    output logic             o_hit,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire t_coord      i_cfg_data
);

    // ------------------------------------------------------------------------
    // Clip rectangle registers, to be written by the user only while no item
    // is in flight; not enforced here, so every stage may read them directly.
    // ------------------------------------------------------------------------
    t_coord r_clip_left, r_clip_top, r_clip_right, r_clip_bottom;
    logic   r_busy;

    assign o_cfg_ready = 1'b1;
    assign busy        = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_left   <= '0;
            r_clip_top    <= '0;
            r_clip_right  <= '0;
            r_clip_bottom <= '0;
            r_busy        <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_CLIP_LEFT:   r_clip_left   <= i_cfg_data;
                    CFG_CLIP_TOP:    r_clip_top    <= i_cfg_data;
                    CFG_CLIP_RIGHT:  r_clip_right  <= i_cfg_data;
                    CFG_CLIP_BOTTOM: r_clip_bottom <= i_cfg_data;
                endcase
            end
        end
    end

    logic accept;
    assign accept = start && !r_busy;

    // ------------------------------------------------------------------------
    // Stage 1: order endpoints by x, clip the x-span to the rectangle.
    // ------------------------------------------------------------------------
    logic   n1_swap;
    t_coord n1_x1, n1_y1, n1_x2, n1_y2, n1_xa, n1_xb;

    always_comb begin
        n1_swap = i_start_x > i_end_x;
        n1_x1   = n1_swap ? i_end_x   : i_start_x;
        n1_y1   = n1_swap ? i_end_y   : i_start_y;
        n1_x2   = n1_swap ? i_start_x : i_end_x;
        n1_y2   = n1_swap ? i_start_y : i_end_y;
        n1_xa   = (n1_x1 > r_clip_left)  ? n1_x1 : r_clip_left;
        n1_xb   = (n1_x2 < r_clip_right) ? n1_x2 : r_clip_right;
    end

    logic   r1_valid;
    t_coord r1_x1, r1_y1, r1_x2, r1_y2, r1_xa, r1_xb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
        end
        r1_x1 <= n1_x1;
        r1_y1 <= n1_y1;
        r1_x2 <= n1_x2;
        r1_y2 <= n1_y2;
        r1_xa <= n1_xa;
        r1_xb <= n1_xb;
    end

    // ------------------------------------------------------------------------
    // Stage 2: differences, empty-span and vertical-segment decisions.
    // ------------------------------------------------------------------------
    t_diff  n2_dx, n2_dy, n2_ea, n2_eb, n2_at, n2_ab;
    logic   n2_empty, n2_vert, n2_vert_hit;
    t_coord n2_lo, n2_hi;

    always_comb begin
        n2_dx    = DIFF_WIDTH'(r1_x2) - DIFF_WIDTH'(r1_x1);
        n2_dy    = DIFF_WIDTH'(r1_y2) - DIFF_WIDTH'(r1_y1);
        n2_ea    = DIFF_WIDTH'(r1_xa) - DIFF_WIDTH'(r1_x1);
        n2_eb    = DIFF_WIDTH'(r1_xb) - DIFF_WIDTH'(r1_x1);
        n2_at    = DIFF_WIDTH'(r1_y1) - DIFF_WIDTH'(r_clip_top);
        n2_ab    = DIFF_WIDTH'(r1_y1) - DIFF_WIDTH'(r_clip_bottom);
        n2_empty = (r1_xa > r1_xb) || (r_clip_top > r_clip_bottom);
        n2_vert  = (r1_x1 == r1_x2);
        n2_lo    = (r1_y1 < r1_y2) ? r1_y1 : r1_y2;
        n2_hi    = (r1_y1 < r1_y2) ? r1_y2 : r1_y1;
        n2_vert_hit = (n2_lo <= r_clip_bottom) && (n2_hi >= r_clip_top);
    end

    logic  r2_valid, r2_empty, r2_vert, r2_vert_hit;
    t_diff r2_dx, r2_dy, r2_ea, r2_eb, r2_at, r2_ab;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_empty    <= n2_empty;
        r2_vert     <= n2_vert;
        r2_vert_hit <= n2_vert_hit;
        r2_dx       <= n2_dx;
        r2_dy       <= n2_dy;
        r2_ea       <= n2_ea;
        r2_eb       <= n2_eb;
        r2_at       <= n2_at;
        r2_ab       <= n2_ab;
    end

    // ------------------------------------------------------------------------
    // Stage 3: four 17x17 signed products. The bound terms (y1 - bound) * dx
    // are shared by both clipped x ends.
    // ------------------------------------------------------------------------
    logic  r3_valid, r3_empty, r3_vert, r3_vert_hit;
    t_prod r3_p_top, r3_p_bot, r3_q_a, r3_q_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_empty    <= r2_empty;
        r3_vert     <= r2_vert;
        r3_vert_hit <= r2_vert_hit;
        r3_p_top    <= r2_at * r2_dx;
        r3_p_bot    <= r2_ab * r2_dx;
        r3_q_a      <= r2_dy * r2_ea;
        r3_q_b      <= r2_dy * r2_eb;
    end

    // ------------------------------------------------------------------------
    // Stage 4: sign of (Y(x) - bound) * dx at each clipped end, with dx > 0.
    // Hit if the line reaches at or below the bottom bound and at or above
    // the top bound somewhere on the clipped span.
    // ------------------------------------------------------------------------
    t_sum n4_top_a, n4_top_b, n4_bot_a, n4_bot_b;
    logic n4_below, n4_above, n4_hit;

    always_comb begin
        n4_top_a = SUM_WIDTH'(r3_p_top) + SUM_WIDTH'(r3_q_a);
        n4_top_b = SUM_WIDTH'(r3_p_top) + SUM_WIDTH'(r3_q_b);
        n4_bot_a = SUM_WIDTH'(r3_p_bot) + SUM_WIDTH'(r3_q_a);
        n4_bot_b = SUM_WIDTH'(r3_p_bot) + SUM_WIDTH'(r3_q_b);
        n4_below = (n4_bot_a <= 0) || (n4_bot_b <= 0);
        n4_above = (n4_top_a >= 0) || (n4_top_b >= 0);
        if (r3_empty) begin
            n4_hit = 1'b0;
        end else if (r3_vert) begin
            n4_hit = r3_vert_hit;
        end else begin
            n4_hit = n4_below && n4_above;
        end
    end

    logic r_hit_valid, r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_hit_valid <= r3_valid;
            r_hit       <= r3_valid && n4_hit;
        end
    end

    assign o_hit_valid = r_hit_valid;
    assign o_hit       = r_hit;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit_valid |-> $past(start && !busy, 4))
        else $error("result strobe without an item accepted four cycles earlier");

    a_hit_needs_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> (r_clip_left <= r_clip_right) && (r_clip_top <= r_clip_bottom))
        else $error("hit reported against an empty clip rectangle");

    a_empty_span_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && r3_empty) |=> (o_hit_valid && !o_hit))
        else $error("empty clipped span did not give a miss");

    a_vert_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && !r3_empty && r3_vert) |=> (o_hit == $past(r3_vert_hit)))
        else $error("vertical segment result lost its span test");

endmodule

`default_nettype wire

// File: dv/segment_rect_intersect_test_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_rect_intersect_test_unit_tb - segment/clip-rectangle hit test bench
// A directed table of segments against a few fixed rectangles runs first:
// reset state, edges, corners, vertical, point and inverted-rectangle cases.
// Random segments follow, in phases with different rectangles and sender
// idle rates. Each item's hit is predicted with exact integer math or taken from
// the row's hand-written value, and checked in order against the o_hit strobe.
// ----------------------------------------------------------------------------

module segment_rect_intersect_test_unit_tb;

    import srit_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int PIPE_LATENCY   = 4;
    localparam int STALL_LIMIT    = 2000;
    localparam int NUM_DIR_ROWS   = 25;
    localparam int NUM_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 212;

    // Directed row: rectangle (left, top, right, bottom), segment, and an
    // optional hand-written hit value.
    typedef struct packed {
        int l;
        int t;
        int r;
        int b;
        int sx;
        int sy;
        int ex;
        int ey;
        bit typed;
        bit hit;
    } t_dir_row;

    // Pending hit, with the segment kept for the mismatch message.
    typedef struct {
        bit     hit;
        int     item_no;
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
    } t_pending_hit;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_coord i_start_x;
    t_coord i_start_y;
    t_coord i_end_x;
    t_coord i_end_y;
    logic   o_hit_valid;
    logic   o_hit;
    logic   i_cfg_valid;
    logic   o_cfg_ready;
    logic [1:0] i_cfg_index;
    t_coord i_cfg_data;

    // Local copy of the clip rectangle, updated on each accepted write.
    t_coord clip_l;
    t_coord clip_t;
    t_coord clip_r;
    t_coord clip_b;

    t_pending_hit pending_hits[$];
    int           mismatch_cnt;
    int           items_sent;
    int           stall_cnt;

    segment_rect_intersect_test_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_hit_valid (o_hit_valid),
        .o_hit       (o_hit),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // Directed table. Rectangles: origin point (reset state), a centered box,
    // the full coordinate plane, inverted in x, inverted in y, and a
    // one-point box at the top-right corner of the plane.
    t_dir_row dir_rows [NUM_DIR_ROWS] = '{
        '{0, 0, 0, 0,             0, 0, 0, 0,                1'b1, 1'b1},
        '{0, 0, 0, 0,             1, 0, 1, 0,                1'b1, 1'b0},
        '{0, 0, 0, 0,             -5, -5, 5, 5,              1'b0, 1'b0},
        '{0, 0, 0, 0,             -5, -4, 5, 5,              1'b0, 1'b0},
        '{-100, -50, 100, 50,     -10, -10, 10, 10,          1'b1, 1'b1},
        '{-100, -50, 100, 50,     -200, 0, -150, 0,          1'b1, 1'b0},
        '{-100, -50, 100, 50,     0, -1000, 0, 1000,         1'b1, 1'b1},
        '{-100, -50, 100, 50,     101, -1000, 101, 1000,     1'b1, 1'b0},
        '{-100, -50, 100, 50,     50, -300, 50, -51,         1'b1, 1'b0},
        '{-100, -50, 100, 50,     -1000, 50, 1000, 50,       1'b1, 1'b1},
        '{-100, -50, 100, 50,     -1000, 51, 1000, 51,       1'b1, 1'b0},
        '{-100, -50, 100, 50,     90, 60, 110, 40,           1'b0, 1'b0},
        '{-100, -50, 100, 50,     91, 60, 111, 40,           1'b0, 1'b0},
        '{-100, -50, 100, 50,     300, -300, -300, 300,      1'b0, 1'b0},
        '{-100, -50, 100, 50,     0, -32768, 1, 32767,       1'b0, 1'b0},
        '{-100, -50, 100, 50,     -32768, -32768, 32767, 32767, 1'b0, 1'b0},
        '{-100, -50, 100, 50,     32767, -32768, -32768, 32767, 1'b0, 1'b0},
        '{-32768, -32768, 32767, 32767, -32768, 32767, -32768, 32767, 1'b1, 1'b1},
        '{-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767,   1'b1, 1'b1},
        '{-32768, -32768, 32767, 32767, -32768, -32768, 32767, -32768, 1'b1, 1'b1},
        '{-32768, -32768, 32767, 32767, 21845, -21846, -21846, 21845, 1'b1, 1'b1},
        '{10, -50, -10, 50,       -1000, 0, 1000, 0,         1'b1, 1'b0},
        '{-100, 50, 100, -50,     0, -1000, 0, 1000,         1'b1, 1'b0},
        '{32767, -32768, 32767, -32768, 32766, -32767, 32767, -32768, 1'b1, 1'b1},
        '{32767, -32768, 32767, -32768, -32768, 32767, 32767, -32767, 1'b0, 1'b0}
    };

    // Sign-carrying numerator of (Y(x) - bnd) * dx for the line through
    // (x1, y1) with slope dy/dx; dx > 0, so its sign is that of Y(x) - bnd.
    function automatic longint line_offset(longint x1, longint y1, longint dx,
                                           longint dy, longint x, longint bnd);
        return (y1 - bnd) * dx + dy * (x - x1);
    endfunction

    // Exact hit prediction against the current clip rectangle.
    function automatic bit predict_hit(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        longint x1, y1, x2, y2, tmp, xa, xb, dx, dy, lo, hi;
        longint cl, ct, cr, cb;
        bit below, above;
        x1 = sx; y1 = sy; x2 = ex; y2 = ey;
        cl = clip_l; ct = clip_t; cr = clip_r; cb = clip_b;
        // order endpoints by x so dx is never negative
        if (x1 > x2) begin
            tmp = x1; x1 = x2; x2 = tmp;
            tmp = y1; y1 = y2; y2 = tmp;
        end
        xa = (x1 > cl) ? x1 : cl;
        xb = (x2 < cr) ? x2 : cr;
        if (xa > xb || ct > cb)
            return 1'b0;
        dx = x2 - x1;
        dy = y2 - y1;
        if (dx == 0) begin
            // vertical or point segment: plain y-span overlap
            lo = (y1 < y2) ? y1 : y2;
            hi = (y1 < y2) ? y2 : y1;
            return (lo <= cb) && (hi >= ct);
        end
        below = line_offset(x1, y1, dx, dy, xa, cb) <= 0 ||
                line_offset(x1, y1, dx, dy, xb, cb) <= 0;
        above = line_offset(x1, y1, dx, dy, xa, ct) >= 0 ||
                line_offset(x1, y1, dx, dy, xb, ct) >= 0;
        return below && above;
    endfunction

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Coordinate biased toward the span [a, b] and its edges, with a share
    // of full-range values so every bit toggles.
    function automatic t_coord pick_coord(int a, int b);
        int lo, hi, v;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        case ($urandom_range(0, 3))
            0: v = rand_between(-32768, 32767);
            1: v = rand_between(lo - 4, hi + 4);
            2: v = lo + rand_between(-8, 8);
            default: v = hi + rand_between(-8, 8);
        endcase
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return t_coord'(v);
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_cnt++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // One register write on the config channel; inputs move on falling edges.
    task automatic write_reg(t_cfg_idx idx, t_coord value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_CLIP_LEFT:   clip_l = value;
            CFG_CLIP_TOP:    clip_t = value;
            CFG_CLIP_RIGHT:  clip_r = value;
            CFG_CLIP_BOTTOM: clip_b = value;
        endcase
    endtask

    // Stop sending, let every pending hit come back, then idle on for a margin.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic set_rect(int l, int t, int r, int b);
        drain();
        write_reg(CFG_CLIP_LEFT,   t_coord'(l));
        write_reg(CFG_CLIP_TOP,    t_coord'(t));
        write_reg(CFG_CLIP_RIGHT,  t_coord'(r));
        write_reg(CFG_CLIP_BOTTOM, t_coord'(b));
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Send one segment; start drops only on idle cycles, so back-to-back
    // items keep it high. A typed hit replaces the predicted one.
    task automatic send_segment(t_coord sx, t_coord sy, t_coord ex, t_coord ey,
                                bit typed, bit typed_hit, int idle_pct);
        t_pending_hit ph;
        @(negedge i_clk);
        while (int'($urandom_range(0, 99)) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start     = 1'b1;
        i_start_x = sx;
        i_start_y = sy;
        i_end_x   = ex;
        i_end_y   = ey;
        do @(posedge i_clk); while (busy);
        ph.hit     = typed ? typed_hit : predict_hit(sx, sy, ex, ey);
        ph.item_no = items_sent;
        ph.sx = sx; ph.sy = sy; ph.ex = ex; ph.ey = ey;
        pending_hits.push_back(ph);
        items_sent++;
    endtask

    // Result checker and no-progress watchdog.
    always @(posedge i_clk) begin
        t_pending_hit ph;
        if (i_rst_n && o_hit_valid === 1'b1) begin
            if (pending_hits.size() == 0) begin
                report_mismatch($sformatf("hit=%0b with no item pending", o_hit));
            end else begin
                ph = pending_hits.pop_front();
                if (o_hit !== ph.hit)
                    report_mismatch($sformatf(
                        "item %0d (%0d,%0d)-(%0d,%0d) rect [%0d,%0d]x[%0d,%0d]: hit=%b exp %0b",
                        ph.item_no, ph.sx, ph.sy, ph.ex, ph.ey,
                        clip_l, clip_r, clip_t, clip_b, o_hit, ph.hit));
            end
        end
        if ((start && !busy) || o_hit_valid || (i_cfg_valid && o_cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int idle_pct [4];
        int rl, rt, rr, rb, w;
        t_coord sx, sy, ex, ey;
        int kind;

        // phases: no idling, sender idle 48/100, no idling (the receiver
        // cannot stall), sender idle 37/100
        idle_pct = '{0, 48, 0, 37};

        start        = 1'b0;
        i_start_x    = '0;
        i_start_y    = '0;
        i_end_x      = '0;
        i_end_y      = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        clip_l = '0; clip_t = '0; clip_r = '0; clip_b = '0;
        mismatch_cnt = 0;
        items_sent   = 0;
        stall_cnt    = 0;

        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part; the first rows run on the reset rectangle.
        foreach (dir_rows[i]) begin
            if (t_coord'(dir_rows[i].l) != clip_l || t_coord'(dir_rows[i].t) != clip_t ||
                t_coord'(dir_rows[i].r) != clip_r || t_coord'(dir_rows[i].b) != clip_b)
                set_rect(dir_rows[i].l, dir_rows[i].t, dir_rows[i].r, dir_rows[i].b);
            send_segment(t_coord'(dir_rows[i].sx), t_coord'(dir_rows[i].sy),
                         t_coord'(dir_rows[i].ex), t_coord'(dir_rows[i].ey),
                         dir_rows[i].typed, dir_rows[i].hit, 0);
        end

        // Random part: one rectangle per phase, extremes among them.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin rl = 0; rt = 0; rr = 0; rb = 0; end
                1: begin
                    rl = rand_between(-2000, 0);  rr = rl + rand_between(0, 3000);
                    rt = rand_between(-2000, 0);  rb = rt + rand_between(0, 3000);
                end
                2: begin rl = -32768; rt = -32768; rr = 32767; rb = 32767; end
                3: begin
                    // inverted in x: empty rectangle
                    rr = rand_between(-500, 400); rl = rr + rand_between(1, 100);
                    rt = rand_between(-500, 0);   rb = rt + rand_between(0, 500);
                end
                4: begin
                    // inverted in y: empty rectangle
                    rl = rand_between(-500, 0);   rr = rl + rand_between(0, 500);
                    rb = rand_between(-500, 400); rt = rb + rand_between(1, 100);
                end
                5: begin
                    rl = rand_between(-32768, 32767); rr = rand_between(-32768, 32767);
                    if (rl > rr) begin w = rl; rl = rr; rr = w; end
                    rt = rand_between(-32768, 32767); rb = rand_between(-32768, 32767);
                    if (rt > rb) begin w = rt; rt = rb; rb = w; end
                end
                6: begin
                    // zero-width column
                    rl = rand_between(-1000, 1000); rr = rl;
                    rt = rand_between(-1000, 0);    rb = rt + rand_between(0, 2000);
                end
                default: begin rl = 32000; rt = 32000; rr = 32767; rb = 32767; end
            endcase
            set_rect(rl, rt, rr, rb);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                sx = pick_coord(rl, rr);
                sy = pick_coord(rt, rb);
                kind = $urandom_range(0, 19);
                if (kind < 2) begin
                    // vertical segment
                    ex = sx;
                    ey = pick_coord(rt, rb);
                end else if (kind < 3) begin
                    // point segment
                    ex = sx;
                    ey = sy;
                end else if (kind < 4) begin
                    // horizontal segment
                    ex = pick_coord(rl, rr);
                    ey = sy;
                end else begin
                    ex = pick_coord(rl, rr);
                    ey = pick_coord(rt, rb);
                end
                send_segment(sx, sy, ex, ey, 1'b0, 1'b0, idle_pct[ph % 4]);
            end
        end

        drain();
        if (mismatch_cnt == 0 && pending_hits.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
